/* hw/rtl/tcw_pkg.sv */
// Shared types, constants and control/status structs for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_top; depends on nothing.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the stream beats
    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 11;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // Bit positions inside s_tdata
    localparam int ACTION_LSB = 0;
    localparam int CHAR_LSB   = ACTION_LSB + ACTION_W;
    localparam int COLOR_LSB  = CHAR_LSB + CHAR_W;
    localparam int INDEX_LSB  = COLOR_LSB + COLOR_W;
    localparam int S_USED_W   = INDEX_LSB + INDEX_W;
    localparam int M_USED_W   = POS_W + CELL_W;

    // Character codes and cell constants
    localparam logic [CHAR_W-1:0]  CH_NEWLINE      = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE    = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK        = 8'h20;
    localparam logic [CELL_W-1:0]  RESET_CELL      = 16'h0720;
    localparam logic [COLOR_W-1:0] FILL_ATTR_RESET = 8'd7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_CLEAR,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_PUT,
        WR_INIT,
        WR_FILL,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ITEM,
        RD_COPY
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clear;
        logic    cnt_inc;
        logic    put_exec;
        logic    home_cursor;
        logic    load_out;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t in_action;
        logic    put_scroll;
        logic    cnt_zero;
        logic    cnt_copy_end;
        logic    cnt_last;
        logic    out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
module tcw_ram #(
    parameter int   WIDTH = 16,
    parameter int   DEPTH = 2000,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer.
// Depends on tcw_pkg (state, command and status types).
module tcw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tcw_pkg::dp_stat_t   stat,
    output tcw_pkg::ctrl_cmd_t  cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.wr_sel      = tcw_pkg::WR_NONE;
        cmd.rd_sel      = tcw_pkg::RD_NONE;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd.wr_sel  = tcw_pkg::WR_INIT;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    unique case (stat.in_action)
                        tcw_pkg::ACT_PUT:   state_next = tcw_pkg::ST_PUT;
                        tcw_pkg::ACT_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        tcw_pkg::ACT_READ:  state_next = tcw_pkg::ST_READ;
                        tcw_pkg::ACT_NONE:  state_next = tcw_pkg::ST_DONE;
                        default:            state_next = tcw_pkg::ST_DONE;
                    endcase
                end
            end
            tcw_pkg::ST_PUT: begin
                cmd.put_exec = 1'b1;
                cmd.wr_sel   = tcw_pkg::WR_PUT;
                state_next   = stat.put_scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_READ: begin
                cmd.rd_sel = tcw_pkg::RD_ITEM;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_CLEAR: begin
                cmd.wr_sel  = tcw_pkg::WR_FILL;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    cmd.home_cursor = 1'b1;
                    state_next      = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_COPY: begin
                // read row below, write the word fetched last cycle one row up
                cmd.wr_sel = stat.cnt_zero ? tcw_pkg::WR_NONE : tcw_pkg::WR_COPY;
                if (stat.cnt_copy_end) begin
                    state_next = tcw_pkg::ST_FILL;
                end else begin
                    cmd.rd_sel  = tcw_pkg::RD_COPY;
                    cmd.cnt_inc = 1'b1;
                end
            end
            tcw_pkg::ST_FILL: begin
                cmd.wr_sel  = tcw_pkg::WR_FILL;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tcw_datapath.sv */
// Datapath of the text console writer: cursor, sweep counter, screen store, output register.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_wr_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    input  tcw_pkg::ctrl_cmd_t                cmd,
    output tcw_pkg::dp_stat_t                 stat
);

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // Item fields
    tcw_pkg::action_t                 item_action_reg;
    logic [tcw_pkg::CHAR_W-1:0]       item_char_reg;
    logic [tcw_pkg::COLOR_W-1:0]      item_color_reg;
    logic [tcw_pkg::INDEX_W-1:0]      item_index_reg;

    logic [COL_W-1:0]                 cursor_col_reg;
    logic [COL_W-1:0]                 cursor_col_next;
    logic [ROW_W-1:0]                 cursor_row_reg;
    logic [ROW_W-1:0]                 cursor_row_next;
    logic [ROW_W:0]                   row_ext;
    logic [COL_W:0]                   col_inc;
    logic [ROW_W:0]                   row_inc;
    logic                             put_scroll;

    logic [ADDR_W-1:0]                cnt_reg;
    logic [ADDR_W-1:0]                cur_addr;
    logic [ADDR_W-1:0]                put_addr;
    logic [tcw_pkg::CELL_W-1:0]       put_data;
    logic                             is_newline;
    logic                             is_backspace;

    logic [tcw_pkg::COLOR_W-1:0]      fill_attr_reg;

    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [tcw_pkg::CELL_W-1:0]       wr_data;
    logic                             rd_en;
    logic [ADDR_W-1:0]                rd_addr;
    logic [tcw_pkg::CELL_W-1:0]       rd_data;

    logic                             read_hit;
    logic [tcw_pkg::CELL_W-1:0]       out_cell;
    logic [tcw_pkg::POS_W-1:0]        out_pos;
    logic                             m_tvalid_reg;
    logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata_reg;

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_action_reg <= tcw_pkg::action_t'(
                s_tdata[tcw_pkg::ACTION_LSB +: tcw_pkg::ACTION_W]);
            item_char_reg   <= s_tdata[tcw_pkg::CHAR_LSB +: tcw_pkg::CHAR_W];
            item_color_reg  <= s_tdata[tcw_pkg::COLOR_LSB +: tcw_pkg::COLOR_W];
            item_index_reg  <= s_tdata[tcw_pkg::INDEX_LSB +: tcw_pkg::INDEX_W];
        end
    end

    // Fill attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_attr_reg <= tcw_pkg::FILL_ATTR_RESET;
        end else if (cfg_wr_en) begin
            fill_attr_reg <= cfg_wr_data;
        end
    end

    assign cur_addr     = ADDR_W'(cursor_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_reg);
    assign is_newline   = (item_char_reg == tcw_pkg::CH_NEWLINE);
    assign is_backspace = (item_char_reg == tcw_pkg::CH_BACKSPACE);
    assign col_inc      = {1'b0, cursor_col_reg} + (COL_W+1)'(1);
    assign row_inc      = {1'b0, cursor_row_reg} + (ROW_W+1)'(1);

    // Cursor move for a put
    always_comb begin
        cursor_col_next = cursor_col_reg;
        row_ext         = {1'b0, cursor_row_reg};
        if (is_newline) begin
            cursor_col_next = '0;
            row_ext         = row_inc;
        end else if (is_backspace) begin
            if (cursor_col_reg != '0) begin
                cursor_col_next = cursor_col_reg - COL_W'(1);
            end else if (cursor_row_reg != '0) begin
                cursor_col_next = COL_W'(COLUMNS - 1);
                row_ext         = {1'b0, cursor_row_reg - ROW_W'(1)};
            end
        end else if (col_inc == (COL_W+1)'(COLUMNS)) begin
            cursor_col_next = '0;
            row_ext         = row_inc;
        end else begin
            cursor_col_next = col_inc[COL_W-1:0];
        end
        put_scroll      = (row_ext == (ROW_W+1)'(ROWS));
        cursor_row_next = put_scroll ? ROW_W'(ROWS - 1) : row_ext[ROW_W-1:0];
    end

    // Backspace steps back one linear cell, except at the origin
    assign put_addr = (is_backspace && cur_addr != '0) ? cur_addr - ADDR_W'(1) : cur_addr;
    assign put_data = {item_color_reg, is_backspace ? tcw_pkg::CH_BLANK : item_char_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end else if (cmd.home_cursor) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end else if (cmd.put_exec) begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    // Sweep counter for init, clear and scroll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
    end

    // Write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = rd_data;
        case (cmd.wr_sel)
            tcw_pkg::WR_PUT: begin
                wr_en   = !is_newline;
                wr_addr = put_addr;
                wr_data = put_data;
            end
            tcw_pkg::WR_INIT: begin
                wr_en   = 1'b1;
                wr_data = tcw_pkg::RESET_CELL;
            end
            tcw_pkg::WR_FILL: begin
                wr_en   = 1'b1;
                wr_data = {fill_attr_reg, tcw_pkg::CH_BLANK};
            end
            tcw_pkg::WR_COPY: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg - ADDR_W'(1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Read port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cnt_reg;
        case (cmd.rd_sel)
            tcw_pkg::RD_ITEM: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(item_index_reg);
            end
            tcw_pkg::RD_COPY: begin
                rd_en   = 1'b1;
                rd_addr = cnt_reg + ADDR_W'(COLUMNS);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (NCELLS)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register
    assign read_hit = (item_action_reg == tcw_pkg::ACT_READ) &&
                      (32'(item_index_reg) < 32'(NCELLS));
    assign out_cell = read_hit ? rd_data : '0;
    assign out_pos  = tcw_pkg::POS_W'(cur_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {(tcw_pkg::M_TDATA_W - tcw_pkg::M_USED_W)'(0), out_cell, out_pos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stat              = '0;
        stat.in_action    = tcw_pkg::action_t'(
                                s_tdata[tcw_pkg::ACTION_LSB +: tcw_pkg::ACTION_W]);
        stat.put_scroll   = put_scroll;
        stat.cnt_zero     = (cnt_reg == '0);
        stat.cnt_copy_end = (cnt_reg == ADDR_W'(NCELLS - COLUMNS));
        stat.cnt_last     = (cnt_reg == ADDR_W'(NCELLS - 1));
        stat.out_free     = !m_tvalid_reg || m_tready;
    end

`ifndef ASSERT_OFF
    a_cursor_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cursor_col_reg) < COLUMNS) && (32'(cursor_row_reg) < ROWS))
        else $error("cursor outside the screen");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= NCELLS)
        else $error("sweep counter beyond the store");

    a_copy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_sel == tcw_pkg::WR_COPY) |->
            (cnt_reg != '0) && ($past(cmd.rd_sel) == tcw_pkg::RD_COPY))
        else $error("scroll copy write without a preceding row read");
`endif

endmodule

/* hw/rtl/text_console_writer_top.sv */
// A put or read passes the PUT or READ state and then DONE, where its result is loaded into
// the result register; the next beat is taken only after that load. A scroll adds a copy sweep
// and a fill sweep and a clear a fill sweep, paced by the single write port of the screen store.
// Reset (aresetn low, synchronous) homes the cursor, sets fill_attribute to 7, then runs a
// clearing pass over all COLUMNS*ROWS cells (2000 by default) writing 0x0720 to each while
// s_tready stays low; configuration writes are taken during the pass.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] action, [9:2] char_code, [17:10] color, [28:18] cell_index, [31:29] zero
    input  logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    // fill_attribute register write
    input  logic                              cfg_wr_en,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_wr_data
);

    // Commands from the controller, status back from the datapath
    tcw_pkg::ctrl_cmd_t cmd;
    tcw_pkg::dp_stat_t  stat;

    // Controller: sequence init sweep, put, read, clear, scroll copy/fill and result hand-off
    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: hold cursor, screen store, sweep counter and the result register; the
    // result register lets the next beat in while a finished result still waits
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
